@@ rtl/button_debounce_long_press_macros.svh @@
// Assertion macros used by the port-level checker of the button debouncer.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define BDLP_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Clocked assertion that is also checked during reset.
`define BDLP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/bdlp_pkg.sv @@
// Types, codes and constants of the button debouncer with long-press repeat.
package bdlp_pkg;

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_DEBOUNCING = 6'b000010,
    ST_PRESSED    = 6'b000100,
    ST_DOWN       = 6'b001000,
    ST_HELD       = 6'b010000,
    ST_RELEASED   = 6'b100000
  } state_e;

  typedef logic [2:0] code_t;
  typedef logic [7:0] count_t;

  localparam code_t CODE_IDLE       = 3'd0;
  localparam code_t CODE_DEBOUNCING = 3'd1;
  localparam code_t CODE_PRESSED    = 3'd2;
  localparam code_t CODE_DOWN       = 3'd3;
  localparam code_t CODE_HELD       = 3'd4;
  localparam code_t CODE_RELEASED   = 3'd5;

  localparam logic CFG_DEBOUNCE   = 1'b0;
  localparam logic CFG_LONG_PRESS = 1'b1;

  localparam count_t DEBOUNCE_RESET   = 8'd5;
  localparam count_t LONG_PRESS_RESET = 8'd100;
  localparam count_t COUNT_MAX        = 8'd255;

  typedef struct packed {
    state_e state;
    count_t count;
  } fsm_t;

  function automatic code_t state_code(state_e s);
    code_t c;
    case (s)
      ST_IDLE:       c = CODE_IDLE;
      ST_DEBOUNCING: c = CODE_DEBOUNCING;
      ST_PRESSED:    c = CODE_PRESSED;
      ST_DOWN:       c = CODE_DOWN;
      ST_HELD:       c = CODE_HELD;
      ST_RELEASED:   c = CODE_RELEASED;
      default:       c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/bdlp_if.sv @@
// Valid/ready channel interfaces for the tick input and the result output.
interface bdlp_in_if;
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface bdlp_out_if;
  logic                 valid;
  logic                 ready;
  bdlp_pkg::code_t      button_state;
  logic                 held_event;
  logic                 short_press_event;

  modport source (output valid, output button_state, output held_event,
                  output short_press_event, input ready);
  modport sink (input valid, input button_state, input held_event,
                input short_press_event, output ready);
endinterface

@@ rtl/bdlp_next.sv @@
// Next-state and counter logic of the debounce and long-press state machine.
module bdlp_next (
  input  bdlp_pkg::fsm_t   cur_i,
  input  logic             level_i,
  input  bdlp_pkg::count_t debounce_ticks_i,
  input  bdlp_pkg::count_t long_press_ticks_i,
  output bdlp_pkg::fsm_t   nxt_o
);

  bdlp_pkg::count_t count_inc;

  assign count_inc = (cur_i.count == bdlp_pkg::COUNT_MAX) ? cur_i.count
                                                          : cur_i.count + 8'd1;

  always_comb begin
    nxt_o = cur_i;
    case (cur_i.state)
      bdlp_pkg::ST_IDLE: begin
        if (level_i) begin
          nxt_o.state = bdlp_pkg::ST_DEBOUNCING;
          nxt_o.count = '0;
        end
      end
      bdlp_pkg::ST_DEBOUNCING: begin
        // The level is ignored here; only the elapsed ticks matter.
        if (count_inc >= debounce_ticks_i) begin
          nxt_o.state = bdlp_pkg::ST_PRESSED;
          nxt_o.count = '0;
        end else begin
          nxt_o.count = count_inc;
        end
      end
      bdlp_pkg::ST_PRESSED, bdlp_pkg::ST_DOWN: begin
        if (!level_i) begin
          nxt_o.state = (cur_i.state == bdlp_pkg::ST_PRESSED) ? bdlp_pkg::ST_RELEASED
                                                              : bdlp_pkg::ST_IDLE;
        end else if (cur_i.count >= long_press_ticks_i) begin
          nxt_o.state = bdlp_pkg::ST_HELD;
        end else begin
          nxt_o.count = count_inc;
        end
      end
      bdlp_pkg::ST_HELD: begin
        if (!level_i) begin
          nxt_o.state = bdlp_pkg::ST_IDLE;
        end else begin
          nxt_o.state = bdlp_pkg::ST_DOWN;
          nxt_o.count = '0;
        end
      end
      default: begin
        // Released lasts one tick and then falls back to idle, count kept.
        nxt_o.state = bdlp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/button_debounce_long_press.sv @@
// Top level of the button debouncer with long-press repeat.
//
// Each input transaction on in_i is one tick carrying the raw button level.
// Every tick produces exactly one result transaction on out_o: the new
// button state (0 idle, 1 debouncing, 2 pressed, 3 down, 4 held, 5 released)
// with a held flag and a short-press flag.
// The result of a tick is written to the output register at the same edge
// that accepts the tick. Throughput is one tick per cycle while the receiver
// takes each result; the state machine and its counter update together.
// in_i.ready is high whenever the output register is empty or is being
// emptied in the same cycle, so a stalled receiver holds the result and
// stalls the input only while the register stays full.
// The two timing registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i, and should be changed only while no tick is in flight.
// Reset sets the machine to idle with a zero count, loads the timing
// registers with 5 and 100 ticks and empties the output register.
module button_debounce_long_press (
  input  logic             clk_i,
  input  logic             rst_ni,
  bdlp_in_if.sink          in_i,
  bdlp_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  bdlp_pkg::count_t cfg_wdata_i
);

  bdlp_pkg::count_t debounce_ticks_q;
  bdlp_pkg::count_t long_press_ticks_q;
  bdlp_pkg::fsm_t   fsm_q;
  bdlp_pkg::fsm_t   fsm_d;
  logic             out_valid_q;
  bdlp_pkg::code_t  out_state_q;
  logic             held_q;
  logic             short_q;
  logic             in_accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q   <= bdlp_pkg::DEBOUNCE_RESET;
      long_press_ticks_q <= bdlp_pkg::LONG_PRESS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bdlp_pkg::CFG_DEBOUNCE:   debounce_ticks_q   <= cfg_wdata_i;
        bdlp_pkg::CFG_LONG_PRESS: long_press_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bdlp_next u_next (
    .cur_i              (fsm_q),
    .level_i            (in_i.level),
    .debounce_ticks_i   (debounce_ticks_q),
    .long_press_ticks_i (long_press_ticks_q),
    .nxt_o              (fsm_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q.state <= bdlp_pkg::ST_IDLE;
      fsm_q.count <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        fsm_q       <= fsm_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_state_q <= bdlp_pkg::state_code(fsm_d.state);
      held_q      <= (fsm_d.state == bdlp_pkg::ST_HELD);
      short_q     <= (fsm_d.state == bdlp_pkg::ST_RELEASED);
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.button_state      = out_state_q;
  assign out_o.held_event        = held_q;
  assign out_o.short_press_event = short_q;

endmodule

@@ rtl/bdlp_checker.sv @@
// Port-level checks of the button debouncer, bound to its top level.
`include "button_debounce_long_press_macros.svh"

module bdlp_port_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input bdlp_pkg::code_t button_state_i,
  input logic            held_event_i,
  input logic            short_press_event_i
);

  // An accepted tick always leaves a result in the output register.
  `BDLP_ASSERT(a_tick_gives_result, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> out_valid_i)

  // The event flags agree with the state code they belong to.
  `BDLP_ASSERT(a_flags_match_state, clk_i, rst_ni, out_valid_i |-> ((held_event_i == (button_state_i == bdlp_pkg::CODE_HELD)) && (short_press_event_i == (button_state_i == bdlp_pkg::CODE_RELEASED))))

  // A stalled result is held unchanged.
  `BDLP_ASSERT(a_stall_holds, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(button_state_i) && $stable(held_event_i) && $stable(short_press_event_i)))

  // Nothing is offered while reset is applied.
  `BDLP_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_i)

endmodule

bind button_debounce_long_press bdlp_port_checker u_bdlp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .button_state_i      (out_o.button_state),
  .held_event_i        (out_o.held_event),
  .short_press_event_i (out_o.short_press_event)
);

@@ tb/sv/bdlp_checker.sv @@
// Checker that tracks the button debouncer's state and compares every result transaction.
`timescale 1ns / 1ps

module bdlp_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  bdlp_in_if               in_mon,
  bdlp_out_if              out_mon,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  bdlp_pkg::count_t cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o
);
  import bdlp_pkg::*;

  typedef struct packed {
    code_t button_state;
    logic  held_event;
    logic  short_press_event;
  } tick_result_t;

  code_t  fsm_code = CODE_IDLE;
  count_t tick_cnt = '0;
  count_t debounce_len = DEBOUNCE_RESET;
  count_t long_len = LONG_PRESS_RESET;

  tick_result_t tick_results[$];
  tick_result_t got;
  tick_result_t want;
  int           fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = tick_results.size();

  function automatic count_t sat_inc(input count_t v);
    return (v == COUNT_MAX) ? v : count_t'(v + 8'd1);
  endfunction

  // Advances the button state by one tick and returns what the block should report.
  function automatic tick_result_t next_tick(input logic lvl);
    tick_result_t r;
    case (fsm_code)
      CODE_IDLE: begin
        if (lvl) begin
          fsm_code = CODE_DEBOUNCING;
          tick_cnt = '0;
        end
      end
      CODE_DEBOUNCING: begin
        // The level is ignored until the debounce time has run out.
        tick_cnt = sat_inc(tick_cnt);
        if (tick_cnt >= debounce_len) begin
          fsm_code = CODE_PRESSED;
          tick_cnt = '0;
        end
      end
      CODE_PRESSED, CODE_DOWN: begin
        if (!lvl) begin
          fsm_code = (fsm_code == CODE_PRESSED) ? CODE_RELEASED : CODE_IDLE;
        end else if (tick_cnt >= long_len) begin
          fsm_code = CODE_HELD;
        end else begin
          tick_cnt = sat_inc(tick_cnt);
        end
      end
      CODE_HELD: begin
        if (!lvl) begin
          fsm_code = CODE_IDLE;
        end else begin
          fsm_code = CODE_DOWN;
          tick_cnt = '0;
        end
      end
      default: begin
        fsm_code = CODE_IDLE;
      end
    endcase
    r.button_state      = fsm_code;
    r.held_event        = (fsm_code == CODE_HELD);
    r.short_press_event = (fsm_code == CODE_RELEASED);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_code     = CODE_IDLE;
      tick_cnt     = '0;
      debounce_len = DEBOUNCE_RESET;
      long_len     = LONG_PRESS_RESET;
      tick_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DEBOUNCE) begin
          debounce_len = cfg_wdata_i;
        end else begin
          long_len = cfg_wdata_i;
        end
      end
      // A result always belongs to an earlier tick, so it is checked before this
      // edge's tick is added.
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got.button_state      = out_mon.button_state;
        got.held_event        = out_mon.held_event;
        got.short_press_event = out_mon.short_press_event;
        if (tick_results.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: result with no tick outstanding: state %0d held %b short %b",
                     $time, got.button_state, got.held_event, got.short_press_event);
          end
          fails++;
        end else begin
          want = tick_results.pop_front();
          if (got.button_state !== want.button_state ||
              got.held_event !== want.held_event ||
              got.short_press_event !== want.short_press_event) begin
            if (fails < 10) begin
              $display("%0t: mismatch: state exp %0d got %0d, held exp %b got %b, short exp %b got %b",
                       $time, want.button_state, got.button_state, want.held_event,
                       got.held_event, want.short_press_event, got.short_press_event);
            end
            fails++;
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        tick_results.push_back(next_tick(in_mon.level));
      end
    end
  end

endmodule

@@ tb/sv/tb_button_debounce_long_press.sv @@
// Top of the button debouncer testbench: clock, reset, tick stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_button_debounce_long_press;
  import bdlp_pkg::*;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_e;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_we;
  logic   cfg_idx;
  count_t cfg_wdata;
  int     fail_count;
  int     pending;

  bdlp_in_if  in_ch ();
  bdlp_out_if out_ch ();

  button_debounce_long_press u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  bdlp_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // The receiver switches at random between stall patterns.
  rx_mode_e rx_mode = RX_FREE;
  int       rx_left = 0;

  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:     out_ch.ready <= 1'b1;
      RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 9) >= 3);
      RX_PERIODIC: out_ch.ready <= (rx_left % 4 != 0);
      default:     out_ch.ready <= (rx_left % 16 < 4);
    endcase
  end

  int burst_left = 0;
  int ticks_sent = 0;

  // Sends one tick and returns at the falling edge after it was accepted.
  task automatic send_tick(input logic lvl);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.level <= lvl;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic send_levels(input logic [31:0] lv, input int n);
    for (int k = n - 1; k >= 0; k--) begin
      send_tick(lv[k]);
    end
  endtask

  // Stops the sender and waits until every tick has produced its result.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_timing(input count_t deb, input count_t lp);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(negedge clk);
    cfg_idx   <= CFG_LONG_PRESS;
    cfg_wdata <= lp;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One press: a bouncing start, a steady hold and a release that may bounce.
  task automatic press_button(input int deb, input int lp);
    int pick;
    int hold;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      hold = $urandom_range(0, lp);
    end else if (pick < 7) begin
      hold = lp + $urandom_range(0, 3);
    end else begin
      hold = $urandom_range(lp + 1, 3 * (lp + 1) + 2);
    end
    send_tick(1'b1);
    repeat ((deb == 0) ? 1 : deb) send_tick($urandom_range(0, 1));
    repeat (hold) send_tick(1'b1);
    send_tick(1'b0);
    repeat ($urandom_range(0, 3)) send_tick($urandom_range(0, 7) == 0);
  endtask

  initial begin
    int phase;
    int seqs;
    int deb;
    int lp;
    int start_ticks;

    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.level = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_DEBOUNCE;
    cfg_wdata   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset timing: the level is ignored while debouncing, then a short press.
    send_levels(32'b01010111010, 11);
    settle();
    // Zero debounce and zero long press: held and down alternate.
    set_timing(8'd0, 8'd0);
    send_levels(32'b101111011001110, 15);
    settle();

    start_ticks = ticks_sent;
    phase = 0;
    while ((phase < 4 || ticks_sent - start_ticks < 600) && phase < 40) begin
      case (phase)
        0: begin
          deb = 1;
          lp  = 1;
        end
        1: begin
          deb = 0;
          lp  = 0;
        end
        2: begin
          deb = 255;
          lp  = 255;
        end
        3: begin
          deb = 0;
          lp  = 255;
        end
        default: begin
          deb = $urandom_range(0, 8);
          lp  = $urandom_range(0, 12);
        end
      endcase
      // The timing changes while the button may still be held, so a lowered
      // long-press limit can fire on the very next tick.
      set_timing(count_t'(deb), count_t'(lp));
      seqs = (deb > 50 || lp > 50) ? 1 : $urandom_range(4, 10);
      repeat (seqs) begin
        if ($urandom_range(0, 99) < 15) begin
          repeat ($urandom_range(1, 10)) send_tick($urandom_range(0, 1));
        end else begin
          press_button(deb, lp);
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 3)) send_tick(1'b1);
      end
      settle();
      phase++;
    end

    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
